[hdl/rmq_pkg.sv]
// Shared constants and pipeline types for the rotation matrix to quaternion block.
`timescale 1ns / 1ps

package rmq_pkg;

	// Q1.14 fixed point
	localparam int FRAC_BITS = 14;
	localparam int DATA_W    = 16;
	// radicand and trace, signed
	localparam int RAD_W     = 18;
	// radicand shifted by FRAC_BITS
	localparam int N_W       = 32;
	// square root result
	localparam int ROOT_W    = N_W / 2;
	// partial remainder of the square root
	localparam int SREM_W    = ROOT_W + 2;
	// magnitude of a raw numerator
	localparam int VMAG_W    = 17;
	// quotient bits kept
	localparam int Q_W       = 24;
	// divisor 2*sq
	localparam int DSR_W     = ROOT_W + 1;
	// partial remainder of the divider
	localparam int DREM_W    = DSR_W + 1;
	// number of non-major lanes
	localparam int LANES     = 3;
	// pipeline depth
	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = Q_W;
	// cycles from the accepting edge to the edge that samples the registered result
	localparam int LATENCY    = 1 + SQRT_STEPS + 1 + DIV_STEPS + 1;

	localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7FFF;
	localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

	// component that comes straight from the square root
	typedef enum logic [1:0] {
		MAJ_W,
		MAJ_X,
		MAJ_Y,
		MAJ_Z
	} major_t;

	typedef struct packed {
		logic                             valid;
		logic                             invalid;
		major_t                           major;
		logic [LANES-1:0]                 vneg;
		logic [LANES-1:0][VMAG_W-1:0]     vmag;
	} ctl_t;

	typedef struct packed {
		ctl_t               ctl;
		logic [N_W-1:0]     n;
		logic [SREM_W-1:0]  rem;
		logic [ROOT_W-1:0]  root;
	} sqst_t;

	typedef struct packed {
		logic                          valid;
		logic                          invalid;
		major_t                        major;
		logic [LANES-1:0]              vneg;
		logic [ROOT_W-1:0]             qmaj;
		logic [DSR_W-1:0]              dsr;
		logic [LANES-1:0][DREM_W-1:0]  rem;
		logic [LANES-1:0][Q_W-1:0]     qn;
	} dvst_t;

endpackage

[hdl/rotation_matrix_to_quaternion.sv]
// Pipelined fixed-point rotation matrix to quaternion conversion (Shepperd's method).
// Stages: 1 setup, 16 root, 1 prep, 24 divide and 1 output stage; the output stage
//   registers done and the result.
// Throughput: one matrix per cycle; busy is always low, as nothing downstream stalls.
// The rate is set by the bit-per-stage root and divider pipelines, one step per register.
// Reset clears every pipeline register, each stage's valid bit, the done strobe and the outputs.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] m00,
	input  logic signed [DATA_W-1:0] m01,
	input  logic signed [DATA_W-1:0] m02,
	input  logic signed [DATA_W-1:0] m10,
	input  logic signed [DATA_W-1:0] m11,
	input  logic signed [DATA_W-1:0] m12,
	input  logic signed [DATA_W-1:0] m20,
	input  logic signed [DATA_W-1:0] m21,
	input  logic signed [DATA_W-1:0] m22,
	output logic                     done,
	output logic signed [DATA_W-1:0] quat_w,
	output logic signed [DATA_W-1:0] quat_x,
	output logic signed [DATA_W-1:0] quat_y,
	output logic signed [DATA_W-1:0] quat_z,
	output logic                     invalid
);

	// one digit of the square root
	function automatic sqst_t sqrt_step(sqst_t a);
		logic [SREM_W+1:0] t;
		logic [SREM_W+1:0] trial;
		sqst_t             b;
		b     = a;
		t     = {a.rem, a.n[N_W-1 -: 2]};
		trial = (SREM_W+2)'({a.root, 2'b01});
		if (t >= trial) begin
			b.rem  = SREM_W'(t - trial);
			b.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			b.rem  = t[SREM_W-1:0];
			b.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		b.n = {a.n[N_W-3:0], 2'b00};
		return b;
	endfunction

	// one quotient bit per lane
	function automatic dvst_t div_step(dvst_t a);
		logic [DREM_W-1:0] t;
		logic              ge;
		dvst_t             b;
		b = a;
		for (int k = 0; k < LANES; k++) begin
			t  = {a.rem[k][DREM_W-2:0], a.qn[k][Q_W-1]};
			ge = (t >= DREM_W'(a.dsr));
			b.rem[k] = ge ? (t - DREM_W'(a.dsr)) : t;
			b.qn[k]  = {a.qn[k][Q_W-2:0], ge};
		end
		return b;
	endfunction

	// sign and saturate a quotient
	function automatic logic signed [DATA_W-1:0] sat_q(logic neg, logic [Q_W-1:0] q);
		logic signed [DATA_W-1:0] res;
		if (!neg)
			res = (q > Q_W'(32767)) ? SAT_MAX : signed'(q[DATA_W-1:0]);
		else
			res = (q >= Q_W'(32768)) ? SAT_MIN : signed'(DATA_W'(~q[DATA_W-1:0] + 1'b1));
		return res;
	endfunction

	logic accept;
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// ---- stage 1: branch select, radicand and raw numerators ----
	logic signed [RAD_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [RAD_W-1:0] trace, rad;
	logic signed [RAD_W-1:0] num [LANES];
	major_t                  maj;
	ctl_t                    ctl_d;
	ctl_t                    ctl_s1;
	logic [N_W-1:0]          n_s1;

	assign e00 = RAD_W'(m00);
	assign e01 = RAD_W'(m01);
	assign e02 = RAD_W'(m02);
	assign e10 = RAD_W'(m10);
	assign e11 = RAD_W'(m11);
	assign e12 = RAD_W'(m12);
	assign e20 = RAD_W'(m20);
	assign e21 = RAD_W'(m21);
	assign e22 = RAD_W'(m22);
	assign trace = e00 + e11 + e22;

	always_comb begin
		if (trace > 0) begin
			maj    = MAJ_W;
			rad    = trace + RAD_W'(1 << FRAC_BITS);
			num[0] = e21 - e12;
			num[1] = e02 - e20;
			num[2] = e10 - e01;
		end else if (e00 > e11 && e00 > e22) begin
			maj    = MAJ_X;
			rad    = RAD_W'(1 << FRAC_BITS) + e00 - e11 - e22;
			num[0] = e21 - e12;
			num[1] = e01 + e10;
			num[2] = e02 + e20;
		end else if (e11 > e22) begin
			maj    = MAJ_Y;
			rad    = RAD_W'(1 << FRAC_BITS) + e11 - e00 - e22;
			num[0] = e02 - e20;
			num[1] = e01 + e10;
			num[2] = e12 + e21;
		end else begin
			maj    = MAJ_Z;
			rad    = RAD_W'(1 << FRAC_BITS) + e22 - e00 - e11;
			num[0] = e10 - e01;
			num[1] = e02 + e20;
			num[2] = e12 + e21;
		end
		ctl_d.valid   = accept;
		ctl_d.invalid = (rad <= 0);
		ctl_d.major   = maj;
		for (int k = 0; k < LANES; k++) begin
			ctl_d.vneg[k] = num[k][RAD_W-1];
			ctl_d.vmag[k] = num[k][RAD_W-1] ? VMAG_W'(-num[k]) : VMAG_W'(num[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			n_s1   <= '0;
		end else begin
			ctl_s1 <= ctl_d;
			n_s1   <= N_W'({rad[RAD_W-2:0], {FRAC_BITS{1'b0}}});
		end
	end

	// ---- square root pipeline, one root bit per stage ----
	sqst_t sq_s [SQRT_STEPS];
	sqst_t sq_init;

	always_comb begin
		sq_init.ctl  = ctl_s1;
		sq_init.n    = n_s1;
		sq_init.rem  = '0;
		sq_init.root = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SQRT_STEPS; i++)
				sq_s[i] <= '0;
		end else begin
			sq_s[0] <= sqrt_step(sq_init);
			for (int i = 1; i < SQRT_STEPS; i++)
				sq_s[i] <= sqrt_step(sq_s[i-1]);
		end
	end

	// ---- divider setup: dividend = |v| << FRAC_BITS + sq, divisor = 2*sq ----
	dvst_t dv_init;
	dvst_t dv_s [DIV_STEPS+1];

	always_comb begin
		logic [ROOT_W-1:0] sq;
		logic [N_W-1:0]    dvd;
		sq               = sq_s[SQRT_STEPS-1].root;
		dv_init.valid    = sq_s[SQRT_STEPS-1].ctl.valid;
		dv_init.invalid  = sq_s[SQRT_STEPS-1].ctl.invalid;
		dv_init.major    = sq_s[SQRT_STEPS-1].ctl.major;
		dv_init.vneg     = sq_s[SQRT_STEPS-1].ctl.vneg;
		dv_init.qmaj     = ROOT_W'(((ROOT_W+1)'(sq) + 1'b1) >> 1);
		dv_init.dsr      = {sq, 1'b0};
		for (int k = 0; k < LANES; k++) begin
			dvd = N_W'({sq_s[SQRT_STEPS-1].ctl.vmag[k], {FRAC_BITS{1'b0}}}) + N_W'(sq);
			dv_init.rem[k] = DREM_W'(dvd[N_W-1:Q_W]);
			dv_init.qn[k]  = dvd[Q_W-1:0];
		end
	end

	// ---- divider pipeline, one quotient bit per stage ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DIV_STEPS; i++)
				dv_s[i] <= '0;
		end else begin
			dv_s[0] <= dv_init;
			for (int i = 1; i <= DIV_STEPS; i++)
				dv_s[i] <= div_step(dv_s[i-1]);
		end
	end

	// ---- output stage: sign, saturate, place the components ----
	logic signed [DATA_W-1:0] lane_q [LANES];
	logic signed [DATA_W-1:0] qmaj_s;
	logic signed [DATA_W-1:0] w_d, x_d, y_d, z_d;

	always_comb begin
		for (int k = 0; k < LANES; k++)
			lane_q[k] = sat_q(dv_s[DIV_STEPS].vneg[k], dv_s[DIV_STEPS].qn[k]);
		qmaj_s = signed'(dv_s[DIV_STEPS].qmaj);
		unique case (dv_s[DIV_STEPS].major)
			MAJ_W: begin
				w_d = qmaj_s;    x_d = lane_q[0]; y_d = lane_q[1]; z_d = lane_q[2];
			end
			MAJ_X: begin
				w_d = lane_q[0]; x_d = qmaj_s;    y_d = lane_q[1]; z_d = lane_q[2];
			end
			MAJ_Y: begin
				w_d = lane_q[0]; x_d = lane_q[1]; y_d = qmaj_s;    z_d = lane_q[2];
			end
			default: begin
				w_d = lane_q[0]; x_d = lane_q[1]; y_d = lane_q[2]; z_d = qmaj_s;
			end
		endcase
		if (dv_s[DIV_STEPS].invalid) begin
			w_d = '0; x_d = '0; y_d = '0; z_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done    <= 1'b0;
			invalid <= 1'b0;
			quat_w  <= '0;
			quat_x  <= '0;
			quat_y  <= '0;
			quat_z  <= '0;
		end else begin
			done    <= dv_s[DIV_STEPS].valid;
			invalid <= dv_s[DIV_STEPS].invalid;
			quat_w  <= w_d;
			quat_x  <= x_d;
			quat_y  <= y_d;
			quat_z  <= z_d;
		end
	end

endmodule

[hdl/rmq_checker.sv]
// Port-level checker for the rotation matrix to quaternion block, with its bind.
`timescale 1ns / 1ps

module rmq_checker import rmq_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic signed [DATA_W-1:0] quat_w,
	input logic signed [DATA_W-1:0] quat_x,
	input logic signed [DATA_W-1:0] quat_y,
	input logic signed [DATA_W-1:0] quat_z,
	input logic                     invalid
);

	// the pipeline never refuses a transaction
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// every accepted transaction yields a result after the fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(LATENCY) done)
		else $error("result missing");

	// no result without a matching transaction
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("unexpected result");

	// an invalid result carries a zero quaternion
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && invalid) |-> (quat_w == 0 && quat_x == 0 && quat_y == 0 && quat_z == 0))
		else $error("invalid result not zero");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.quat_w  (quat_w),
	.quat_x  (quat_x),
	.quat_y  (quat_y),
	.quat_z  (quat_z),
	.invalid (invalid)
);

[tb/rotation_matrix_to_quaternion_tb.sv]
// Self-checking testbench for the rotation matrix to quaternion block.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;
	import rmq_pkg::*;

	typedef logic signed [DATA_W-1:0] elem_t;

	typedef struct {
		elem_t m [9];
	} matrix_t;

	typedef struct {
		elem_t w, x, y, z;
		logic  bad;
	} quat_t;

	// directed row: matrix, plus an optional hand-typed quaternion
	typedef struct {
		matrix_t mat;
		logic    known;
		quat_t   q;
	} row_t;

	localparam int MAX_CYCLES = 400000;
	localparam int N_RANDOM   = 1000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	elem_t m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0;
	elem_t m12 = '0, m20 = '0, m21 = '0, m22 = '0;
	logic  done;
	elem_t quat_w, quat_x, quat_y, quat_z;
	logic  invalid;

	quat_t pending_quats [$];
	int    mismatches = 0;
	int    cycles = 0;

	rotation_matrix_to_quaternion dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// integer square root, bit by bit
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// v * 2^FRAC_BITS / (2*root), round half away from zero
	function automatic longint off_axis(longint v, longint unsigned root);
		longint unsigned mag, q;
		if (root == 0) return 0;
		mag = (v < 0) ? longint'(-v) : v;
		mag <<= FRAC_BITS;
		q = (mag + root) / (2 * root);
		return (v < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic elem_t clamp16(longint v);
		if (v > 32767) return SAT_MAX;
		if (v < -32768) return SAT_MIN;
		return elem_t'(v);
	endfunction

	// Shepperd's method in exact integers
	function automatic quat_t matrix_to_quat(matrix_t a);
		longint e [9];
		longint tr, rad;
		longint num [4];
		longint unsigned root;
		major_t maj;
		quat_t q;
		for (int i = 0; i < 9; i++) e[i] = a.m[i];
		tr = e[0] + e[4] + e[8];
		num = '{0, 0, 0, 0};
		if (tr > 0) begin
			maj = MAJ_W;
			rad = tr + (64'sd1 << FRAC_BITS);
			num[1] = e[7] - e[5]; num[2] = e[2] - e[6]; num[3] = e[3] - e[1];
		end else if (e[0] > e[4] && e[0] > e[8]) begin
			maj = MAJ_X;
			rad = (64'sd1 << FRAC_BITS) + e[0] - e[4] - e[8];
			num[0] = e[7] - e[5]; num[2] = e[1] + e[3]; num[3] = e[2] + e[6];
		end else if (e[4] > e[8]) begin
			maj = MAJ_Y;
			rad = (64'sd1 << FRAC_BITS) + e[4] - e[0] - e[8];
			num[0] = e[2] - e[6]; num[1] = e[1] + e[3]; num[3] = e[5] + e[7];
		end else begin
			maj = MAJ_Z;
			rad = (64'sd1 << FRAC_BITS) + e[8] - e[0] - e[4];
			num[0] = e[3] - e[1]; num[1] = e[2] + e[6]; num[2] = e[5] + e[7];
		end
		if (rad <= 0) begin
			q = '{w: '0, x: '0, y: '0, z: '0, bad: 1'b1};
			return q;
		end
		root = int_sqrt(longint'(rad) << FRAC_BITS);
		for (int i = 0; i < 4; i++)
			if (i == int'(maj)) num[i] = longint'((root + 1) >> 1);
			else num[i] = off_axis(num[i], root);
		q.w = clamp16(num[0]);
		q.x = clamp16(num[1]);
		q.y = clamp16(num[2]);
		q.z = clamp16(num[3]);
		q.bad = 1'b0;
		return q;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	// result checker; done cannot be held off
	always @(posedge clk) begin
		quat_t want;
		cycles++;
		if (done) begin
			if (pending_quats.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				want = pending_quats.pop_front();
				if (quat_w !== want.w) report("quat_w", quat_w, want.w);
				if (quat_x !== want.x) report("quat_x", quat_x, want.x);
				if (quat_y !== want.y) report("quat_y", quat_y, want.y);
				if (quat_z !== want.z) report("quat_z", quat_z, want.z);
				if (invalid !== want.bad) report("invalid", invalid, want.bad);
			end
		end
		if (cycles > MAX_CYCLES) begin
			$display("timeout");
			$display("*** FAILED ***");
			$finish;
		end
	end

	// drive one transaction; returns after the accepting edge, on a falling edge
	task automatic send_matrix(matrix_t a, quat_t want);
		{m00, m01, m02, m10, m11, m12, m20, m21, m22} =
			{a.m[0], a.m[1], a.m[2], a.m[3], a.m[4], a.m[5], a.m[6], a.m[7], a.m[8]};
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_quats.push_back(want);
		@(negedge clk);
	endtask

	function automatic elem_t rnd_elem();
		case ($urandom_range(0, 5))
			0: return SAT_MAX;
			1: return SAT_MIN;
			2: return elem_t'($urandom_range(0, 32767) - 16384);
			default: return elem_t'($urandom);
		endcase
	endfunction

	// mostly true rotations built from a random unit quaternion
	function automatic matrix_t rnd_matrix();
		matrix_t a;
		real qw, qx, qy, qz, nrm, s;
		real r [9];
		if ($urandom_range(0, 3) == 0) begin
			for (int i = 0; i < 9; i++) a.m[i] = rnd_elem();
			return a;
		end
		qw = $urandom_range(0, 2000) - 1000.0;
		qx = $urandom_range(0, 2000) - 1000.0;
		qy = $urandom_range(0, 2000) - 1000.0;
		qz = $urandom_range(0, 2000) - 1000.0;
		nrm = qw*qw + qx*qx + qy*qy + qz*qz;
		if (nrm == 0.0) nrm = 1.0;
		s = 2.0 / nrm;
		r[0] = 1 - s*(qy*qy + qz*qz); r[1] = s*(qx*qy - qz*qw); r[2] = s*(qx*qz + qy*qw);
		r[3] = s*(qx*qy + qz*qw); r[4] = 1 - s*(qx*qx + qz*qz); r[5] = s*(qy*qz - qx*qw);
		r[6] = s*(qx*qz - qy*qw); r[7] = s*(qy*qz + qx*qw); r[8] = 1 - s*(qx*qx + qy*qy);
		for (int i = 0; i < 9; i++)
			a.m[i] = elem_t'($rtoi(r[i] * 16384.0) + $signed($urandom_range(0, 6)) - 3);
		return a;
	endfunction

	function automatic row_t mk(elem_t a0, a1, a2, a3, a4, a5, a6, a7, a8);
		row_t r;
		r.mat.m = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
		r.known = 1'b0;
		r.q = '{w: '0, x: '0, y: '0, z: '0, bad: 1'b0};
		return r;
	endfunction

	function automatic row_t mk_known(row_t r, elem_t w, x, y, z, logic bad);
		r.known = 1'b1;
		r.q = '{w: w, x: x, y: y, z: z, bad: bad};
		return r;
	endfunction

	initial begin
		row_t    rows [$];
		matrix_t a;
		quat_t   want;
		int      burst;
		int      gap;

		// identity: w = 0.5 * sqrt(4) = 1.0
		rows.push_back(mk_known(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384),
			16384, 0, 0, 0, 1'b0));
		// all zero: trace 0, m22 branch, r = ONE, z = 0.5
		rows.push_back(mk_known(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 8192, 1'b0));
		// x branch with r = 4.0: x = 1.0, everything else zero
		rows.push_back(mk_known(mk(-16384, 0, 0, 0, -32768, 0, 0, 0, -32768),
			0, 16384, 0, 0, 1'b0));
		// m00 ties m11, so the y branch takes it
		rows.push_back(mk(16383, 0, 0, 0, 16383, 0, 0, 0, -32768));
		// 180 degree turns about each axis
		rows.push_back(mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
		rows.push_back(mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
		rows.push_back(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
		// tied diagonals
		rows.push_back(mk(-8192, 100, 200, 300, -8192, 400, 500, 600, -8192));
		rows.push_back(mk(-100, 1, 2, 3, -100, 4, 5, 6, -9000));
		rows.push_back(mk(-100, 1, 2, 3, -9000, 4, 5, 6, -100));
		// saturating off-axis terms
		rows.push_back(mk(-16384, 32767, -32768, -32768, -16384, 32767, 32767, -32768,
			-16383));
		rows.push_back(mk(32767, -32768, 32767, 32767, -32768, -32768, -32768, 32767,
			-32768));
		// largest positive trace and all minimum
		rows.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		rows.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
			-32768));
		// small positive trace, huge numerators
		rows.push_back(mk(1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0));
		rows.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		rows.push_back(mk(-21846, 5555, -7777, 1234, -32768, -21845, 3, 9, 32767));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (rows[i]) begin
			want = rows[i].known ? rows[i].q : matrix_to_quat(rows[i].mat);
			send_matrix(rows[i].mat, want);
		end
		start <= 1'b0;

		// drain once before random traffic
		while (pending_quats.size() != 0) @(negedge clk);

		// random bursts with random gaps
		for (int n = 0; n < N_RANDOM; ) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
				a = rnd_matrix();
				send_matrix(a, matrix_to_quat(a));
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		if (gap == 0)
			start <= 1'b0;

		while (pending_quats.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
